@@ rtl/source_text_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer.
// Each macro checks a property on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Expression must hold at every edge.
`define STT_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("source_text_tokenizer: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("source_text_tokenizer: implication violated");

// Consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("source_text_tokenizer: next-cycle check violated");

`endif

@@ rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Shared widths, token kind codes, character constants, result types and
// character classification helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    // Counter widths.
    localparam int POS_BITS    = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    localparam logic [POS_BITS-1:0]    POS_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    // Result queue geometry. The depth must be a power of two, since the
    // pointers wrap at their width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [4:0] kind_t;

    // Token kinds.
    localparam kind_t K_IDENT       = 5'd0;
    localparam kind_t K_STRUCT      = 5'd1;
    localparam kind_t K_RETURN      = 5'd2;
    localparam kind_t K_INT         = 5'd3;
    localparam kind_t K_FLOAT       = 5'd4;
    localparam kind_t K_STRING      = 5'd5;
    localparam kind_t K_DOT         = 5'd6;
    localparam kind_t K_DDOT        = 5'd7;
    localparam kind_t K_COMMA       = 5'd8;
    localparam kind_t K_ASSIGN      = 5'd9;
    localparam kind_t K_EQUAL       = 5'd10;
    localparam kind_t K_COLON       = 5'd11;
    localparam kind_t K_SEMI        = 5'd12;
    localparam kind_t K_STAR        = 5'd13;
    localparam kind_t K_AMP         = 5'd14;
    localparam kind_t K_SLASH       = 5'd15;
    localparam kind_t K_PLUS        = 5'd16;
    localparam kind_t K_MINUS       = 5'd17;
    localparam kind_t K_ARROW       = 5'd18;
    localparam kind_t K_LPAR        = 5'd19;
    localparam kind_t K_RPAR        = 5'd20;
    localparam kind_t K_LBRACE      = 5'd21;
    localparam kind_t K_RBRACE      = 5'd22;
    localparam kind_t K_LBRACK      = 5'd23;
    localparam kind_t K_RBRACK      = 5'd24;
    localparam kind_t K_UNKNOWN     = 5'd25;
    localparam kind_t K_UNSUPPORTED = 5'd26;
    localparam kind_t K_END         = 5'd27;

    // Characters with a special role.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [8:0] NL_PAIR_SUM   = 9'd23;

    // One result item.
    typedef struct packed {
        kind_t                  kind;
        logic [POS_BITS-1:0]    start_pos;
        logic [POS_BITS-1:0]    length;
        logic [LINE_BITS-1:0]   line_no;
        logic [COLUMN_BITS-1:0] column_no;
        logic                   number_error;
        logic                   last;
    } result_t;

    // Results produced by one input transfer.
    typedef struct packed {
        logic [1:0]       count;
        result_t [1:0]    item;
    } push_t;

    function automatic result_t make_result(
        input kind_t                  kind,
        input logic [POS_BITS-1:0]    start_pos,
        input logic [POS_BITS-1:0]    length,
        input logic [LINE_BITS-1:0]   line_no,
        input logic [COLUMN_BITS-1:0] column_no,
        input logic                   number_error,
        input logic                   last
    );
        result_t r;
        r.kind         = kind;
        r.start_pos    = start_pos;
        r.length       = length;
        r.line_no      = line_no;
        r.column_no    = column_no;
        r.number_error = number_error;
        r.last         = last;
        return r;
    endfunction

    function automatic logic [POS_BITS-1:0] inc_pos(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
        return (v == COL_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    // TAB, LF, VT, CR and space.
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd9) || (b == 8'd10) || (b == 8'd11) || (b == 8'd13) || (b == 8'd32);
    endfunction

    // Letters of the two keywords, by position.
    function automatic logic [7:0] struct_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "s";
            3'd1:    c = "t";
            3'd2:    c = "r";
            3'd3:    c = "u";
            3'd4:    c = "c";
            3'd5:    c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] return_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "r";
            3'd1:    c = "e";
            3'd2:    c = "t";
            3'd3:    c = "u";
            3'd4:    c = "r";
            3'd5:    c = "n";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Kind of a one-character operator; anything else is unsupported.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            ".":     k = K_DOT;
            "=":     k = K_ASSIGN;
            "-":     k = K_MINUS;
            "/":     k = K_SLASH;
            ",":     k = K_COMMA;
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            "*":     k = K_STAR;
            "&":     k = K_AMP;
            "+":     k = K_PLUS;
            "(":     k = K_LPAR;
            ")":     k = K_RPAR;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            default: k = K_UNSUPPORTED;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte per input transfer, tokens out on the
// result channel.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------
//   s_      | in        | s_valid / s_ready  | byte_req, end_mark
//   m_      | out       | m_valid / m_ready  | kind, start_pos, length,
//           |           |                    | line_no, column_no,
//           |           |                    | number_error, last
//
// One byte is accepted per cycle while s_ready is high; its tokens enter the
// result queue at the same edge and appear on m_ once earlier tokens are taken.
// A byte can yield two tokens; the four-entry result queue then drains one
// token per cycle while m_ready is high, and s_ready drops while more than
// two tokens wait. Reset is synchronous and clears the scanner and the queue.
// An end_mark transfer flushes the open token, emits the end token and
// returns the scanner to its reset state.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_byte_req,
    input  logic                   s_end_mark,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [4:0]             m_kind,
    output logic [POS_BITS-1:0]    m_start_pos,
    output logic [POS_BITS-1:0]    m_length,
    output logic [LINE_BITS-1:0]   m_line_no,
    output logic [COLUMN_BITS-1:0] m_column_no,
    output logic                   m_number_error,
    output logic                   m_last
);

    logic                 in_fire;
    logic                 out_fire;
    push_t                push;
    result_t              head;
    logic [QCNT_BITS-1:0] fill;
    logic                 end_shape_ok;

    // Room for the two tokens one byte can produce.
    assign s_ready  = (fill <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign in_fire  = s_valid & s_ready;
    assign m_valid  = (fill != '0);
    assign out_fire = m_valid & m_ready;

    stt_scanner u_scanner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .in_byte     (s_byte_req),
        .in_end_mark (s_end_mark),
        .push        (push)
    );

    stt_result_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (out_fire),
        .head    (head),
        .fill    (fill)
    );

    // Result channel payload.
    assign m_kind         = head.kind;
    assign m_start_pos    = head.start_pos;
    assign m_length       = head.length;
    assign m_line_no      = head.line_no;
    assign m_column_no    = head.column_no;
    assign m_number_error = head.number_error;
    assign m_last         = head.last;

    // The end token is an empty token without a number error.
    assign end_shape_ok = (m_kind == K_END) && (m_length == '0) && !m_number_error;

    // Checks on queue occupancy and token shape.
    `STT_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill <= QCNT_BITS'(QUEUE_DEPTH))
    `STT_ASSERT_IMPLY(a_stall_has_waiting, aclk, aresetn, !s_ready, m_valid)
    `STT_ASSERT_NEXT(a_end_gives_token, aclk, aresetn, in_fire && s_end_mark, m_valid)
    `STT_ASSERT_IMPLY(a_last_shape, aclk, aresetn, m_valid && m_last, end_shape_ok)

endmodule

@@ rtl/stt_scanner.sv @@
// ----------------------------------------------------------------------------
// stt_scanner
// Scanner state and the per-byte update. Each accepted transfer updates the
// state and yields zero, one or two result items.
// ----------------------------------------------------------------------------
module stt_scanner
    import stt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    input  logic       in_end_mark,
    output push_t      push
);

    // Scan modes.
    localparam logic [2:0] M_IDLE       = 3'd0;
    localparam logic [2:0] M_IDENT      = 3'd1;
    localparam logic [2:0] M_NUMBER     = 3'd2;
    localparam logic [2:0] M_NUMBER_DOT = 3'd3;
    localparam logic [2:0] M_OP         = 3'd4;
    localparam logic [2:0] M_STRING     = 3'd5;
    localparam logic [2:0] M_COMMENT    = 3'd6;

    logic [2:0]             mode_reg, mode_next;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0]    tok_start_reg, tok_start_next;
    logic [POS_BITS-1:0]    tok_len_reg, tok_len_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [1:0]             kw_reg, kw_next;
    logic                   seen_dot_reg, seen_dot_next;
    logic                   dot_err_reg, dot_err_next;
    logic [7:0]             pend_char_reg, pend_char_next;
    logic [7:0]             last_nl_reg, last_nl_next;

    logic                   nl_now;
    logic                   do_fresh;
    logic [1:0]             res_cnt;
    result_t                res_a [2];
    kind_t                  ident_kind;

    // Keyword class of the identifier held in the token registers.
    always_comb begin
        if ((tok_len_reg == POS_BITS'(6)) && kw_reg[0]) begin
            ident_kind = K_STRUCT;
        end else if ((tok_len_reg == POS_BITS'(6)) && kw_reg[1]) begin
            ident_kind = K_RETURN;
        end else begin
            ident_kind = K_IDENT;
        end
    end

    // Per-byte state update and token emission.
    always_comb begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        tok_start_next = tok_start_reg;
        tok_len_next   = tok_len_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        kw_next        = kw_reg;
        seen_dot_next  = seen_dot_reg;
        dot_err_next   = dot_err_reg;
        pend_char_next = pend_char_reg;
        last_nl_next   = last_nl_reg;
        nl_now         = 1'b0;
        do_fresh       = 1'b0;
        res_cnt        = 2'd0;
        res_a[0]       = '0;
        res_a[1]       = '0;

        if (in_end_mark) begin
            // Flush the open token, emit the end token, return to reset state.
            unique case (mode_reg)
                M_IDENT: begin
                    res_a[res_cnt[0]] = make_result(ident_kind, tok_start_reg, tok_len_reg,
                                                    tok_line_reg, tok_col_reg, 1'b0, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                M_NUMBER: begin
                    res_a[res_cnt[0]] = make_result(seen_dot_reg ? K_FLOAT : K_INT,
                                                    tok_start_reg, tok_len_reg, tok_line_reg,
                                                    tok_col_reg, dot_err_reg, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                M_NUMBER_DOT: begin
                    // The waiting dot belongs to the number.
                    res_a[res_cnt[0]] = make_result(K_FLOAT, tok_start_reg,
                                                    inc_pos(tok_len_reg), tok_line_reg,
                                                    tok_col_reg, dot_err_reg | seen_dot_reg,
                                                    1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                M_OP: begin
                    res_a[res_cnt[0]] = make_result(single_kind(pend_char_reg), tok_start_reg,
                                                    tok_len_reg, tok_line_reg, tok_col_reg,
                                                    1'b0, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                M_STRING: begin
                    res_a[res_cnt[0]] = make_result(K_STRING, tok_start_reg, tok_len_reg,
                                                    tok_line_reg, tok_col_reg, 1'b0, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
                default: begin
                end
            endcase
            res_a[res_cnt[0]] = make_result(K_END, pos_reg, '0, line_reg, col_reg,
                                            1'b0, 1'b1);
            res_cnt = res_cnt + 2'd1;

            mode_next      = M_IDLE;
            pos_next       = '0;
            line_next      = LINE_BITS'(1);
            col_next       = COLUMN_BITS'(1);
            tok_start_next = '0;
            tok_len_next   = '0;
            tok_line_next  = LINE_BITS'(1);
            tok_col_next   = COLUMN_BITS'(1);
            kw_next        = 2'b11;
            seen_dot_next  = 1'b0;
            dot_err_next   = 1'b0;
            pend_char_next = '0;
            last_nl_next   = '0;
        end else if ((last_nl_reg != 8'd0) &&
                     (({1'b0, in_byte} + {1'b0, last_nl_reg}) == NL_PAIR_SUM)) begin
            // Second byte of a CR LF or LF CR pair: only the position moves.
            last_nl_next = '0;
            pos_next     = inc_pos(pos_reg);
        end else begin
            last_nl_next = '0;

            unique case (mode_reg)
                M_STRING: begin
                    if (in_byte == CH_QUOTE) begin
                        res_a[res_cnt[0]] = make_result(K_STRING, tok_start_reg, tok_len_reg,
                                                        tok_line_reg, tok_col_reg, 1'b0, 1'b0);
                        res_cnt   = res_cnt + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        tok_len_next = inc_pos(tok_len_reg);
                    end
                end
                M_COMMENT: begin
                    if ((in_byte == CH_LF) || (in_byte == CH_CR)) begin
                        do_fresh = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_letter(in_byte) || is_digit(in_byte) ||
                        (in_byte == CH_UNDERSCORE)) begin
                        if ((tok_len_reg >= POS_BITS'(6)) ||
                            (in_byte != struct_char(tok_len_reg[2:0]))) begin
                            kw_next[0] = 1'b0;
                        end
                        if ((tok_len_reg >= POS_BITS'(6)) ||
                            (in_byte != return_char(tok_len_reg[2:0]))) begin
                            kw_next[1] = 1'b0;
                        end
                        tok_len_next = inc_pos(tok_len_reg);
                    end else begin
                        res_a[res_cnt[0]] = make_result(ident_kind, tok_start_reg, tok_len_reg,
                                                        tok_line_reg, tok_col_reg, 1'b0, 1'b0);
                        res_cnt  = res_cnt + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_NUMBER, M_NUMBER_DOT: begin
                    if ((mode_reg == M_NUMBER_DOT) && (in_byte == CH_DOT)) begin
                        // Number ends before the first dot; a range operator follows.
                        res_a[res_cnt[0]] = make_result(seen_dot_reg ? K_FLOAT : K_INT,
                                                        tok_start_reg, tok_len_reg,
                                                        tok_line_reg, tok_col_reg,
                                                        dot_err_reg, 1'b0);
                        res_cnt = res_cnt + 2'd1;
                        res_a[res_cnt[0]] = make_result(
                            K_DDOT,
                            (pos_reg != '0) ? pos_reg - 1'b1 : '0,
                            POS_BITS'(2),
                            line_reg,
                            (col_reg > COLUMN_BITS'(1)) ? col_reg - 1'b1 : COLUMN_BITS'(1),
                            1'b0, 1'b0);
                        res_cnt   = res_cnt + 2'd1;
                        mode_next = M_IDLE;
                    end else begin
                        // A waiting dot joins the number first.
                        if (mode_reg == M_NUMBER_DOT) begin
                            dot_err_next  = dot_err_reg | seen_dot_reg;
                            seen_dot_next = 1'b1;
                            tok_len_next  = inc_pos(tok_len_reg);
                            mode_next     = M_NUMBER;
                        end
                        if (is_digit(in_byte)) begin
                            tok_len_next = inc_pos(tok_len_next);
                        end else if (in_byte == CH_DOT) begin
                            mode_next = M_NUMBER_DOT;
                        end else begin
                            res_a[res_cnt[0]] = make_result(seen_dot_next ? K_FLOAT : K_INT,
                                                            tok_start_reg, tok_len_next,
                                                            tok_line_reg, tok_col_reg,
                                                            dot_err_next, 1'b0);
                            res_cnt  = res_cnt + 2'd1;
                            do_fresh = 1'b1;
                        end
                    end
                end
                M_OP: begin
                    if (((pend_char_reg == CH_DOT) && (in_byte == CH_DOT)) ||
                        ((pend_char_reg == CH_EQ) && (in_byte == CH_EQ)) ||
                        ((pend_char_reg == CH_MINUS) && (in_byte == CH_GT))) begin
                        tok_len_next = POS_BITS'(2);
                        res_a[res_cnt[0]] = make_result(
                            (pend_char_reg == CH_DOT) ? K_DDOT :
                            (pend_char_reg == CH_EQ) ? K_EQUAL : K_ARROW,
                            tok_start_reg, POS_BITS'(2), tok_line_reg, tok_col_reg,
                            1'b0, 1'b0);
                        res_cnt   = res_cnt + 2'd1;
                        mode_next = M_IDLE;
                    end else if ((pend_char_reg == CH_SLASH) && (in_byte == CH_SLASH)) begin
                        mode_next = M_COMMENT;
                    end else begin
                        res_a[res_cnt[0]] = make_result(single_kind(pend_char_reg),
                                                        tok_start_reg, tok_len_reg,
                                                        tok_line_reg, tok_col_reg,
                                                        1'b0, 1'b0);
                        res_cnt  = res_cnt + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase

            // Start of a new token, or a byte seen with the scanner idle.
            if (do_fresh) begin
                mode_next = M_IDLE;
                if (is_letter(in_byte)) begin
                    mode_next      = M_IDENT;
                    tok_start_next = pos_reg;
                    tok_line_next  = line_reg;
                    tok_col_next   = col_reg;
                    tok_len_next   = POS_BITS'(1);
                    kw_next        = {in_byte == return_char(3'd0),
                                      in_byte == struct_char(3'd0)};
                end else if (is_digit(in_byte)) begin
                    mode_next      = M_NUMBER;
                    tok_start_next = pos_reg;
                    tok_line_next  = line_reg;
                    tok_col_next   = col_reg;
                    tok_len_next   = POS_BITS'(1);
                    seen_dot_next  = 1'b0;
                    dot_err_next   = 1'b0;
                end else if (is_space(in_byte)) begin
                    if ((in_byte == CH_LF) || (in_byte == CH_CR)) begin
                        last_nl_next = in_byte;
                        nl_now       = 1'b1;
                    end
                end else if ((in_byte >= 8'd33) && (in_byte <= 8'd126)) begin
                    if (in_byte == CH_QUOTE) begin
                        // String content starts after the quote.
                        mode_next      = M_STRING;
                        tok_start_next = inc_pos(pos_reg);
                        tok_line_next  = line_reg;
                        tok_col_next   = inc_col(col_reg);
                        tok_len_next   = '0;
                    end else if ((in_byte == CH_DOT) || (in_byte == CH_EQ) ||
                                 (in_byte == CH_MINUS) || (in_byte == CH_SLASH)) begin
                        mode_next      = M_OP;
                        pend_char_next = in_byte;
                        tok_start_next = pos_reg;
                        tok_line_next  = line_reg;
                        tok_col_next   = col_reg;
                        tok_len_next   = POS_BITS'(1);
                    end else begin
                        res_a[res_cnt[0]] = make_result(single_kind(in_byte), pos_reg,
                                                        POS_BITS'(1), line_reg, col_reg,
                                                        1'b0, 1'b0);
                        res_cnt = res_cnt + 2'd1;
                    end
                end else begin
                    res_a[res_cnt[0]] = make_result(K_UNKNOWN, pos_reg, POS_BITS'(1),
                                                    line_reg, col_reg, 1'b0, 1'b0);
                    res_cnt = res_cnt + 2'd1;
                end
            end

            // Advance position, line and column.
            pos_next = inc_pos(pos_reg);
            if (nl_now) begin
                line_next = inc_line(line_reg);
                col_next  = COLUMN_BITS'(1);
            end else begin
                col_next = inc_col(col_reg);
            end
        end
    end

    // Results handed to the queue on a transfer.
    assign push.count   = in_fire ? res_cnt : 2'd0;
    assign push.item[0] = res_a[0];
    assign push.item[1] = res_a[1];

    // Scanner state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_IDLE;
            pos_reg       <= '0;
            line_reg      <= LINE_BITS'(1);
            col_reg       <= COLUMN_BITS'(1);
            tok_start_reg <= '0;
            tok_len_reg   <= '0;
            tok_line_reg  <= LINE_BITS'(1);
            tok_col_reg   <= COLUMN_BITS'(1);
            kw_reg        <= 2'b11;
            seen_dot_reg  <= 1'b0;
            dot_err_reg   <= 1'b0;
            pend_char_reg <= '0;
            last_nl_reg   <= '0;
        end else if (in_fire) begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            tok_start_reg <= tok_start_next;
            tok_len_reg   <= tok_len_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            kw_reg        <= kw_next;
            seen_dot_reg  <= seen_dot_next;
            dot_err_reg   <= dot_err_next;
            pend_char_reg <= pend_char_next;
            last_nl_reg   <= last_nl_next;
        end
    end

endmodule

@@ rtl/stt_result_queue.sv @@
// ----------------------------------------------------------------------------
// stt_result_queue
// Small result queue: takes up to two items per cycle from the scanner and
// hands out one item per output transfer.
// ----------------------------------------------------------------------------
module stt_result_queue
    import stt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  push_t                push,
    input  logic                 pop,
    output result_t              head,
    output logic [QCNT_BITS-1:0] fill
);

    result_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] fill_reg, fill_next;
    logic [QPTR_BITS-1:0] wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        fill_next   = fill_reg + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage; the second item goes one slot after the first.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.item[0];
        end
        if (push.count == 2'd2) begin
            q_reg[wr_ptr_second] <= push.item[1];
        end
    end

    assign head = q_reg[rd_ptr_reg];
    assign fill = fill_reg;

endmodule
